// ===== rtl/imu_sbc_pkg.sv =====
// shared widths, codes and handshake types of the imu still bias calibrator
package imu_sbc_pkg;

   localparam int FRAC_BITS = 8;
   localparam int SUM_W     = 32;
   localparam int SMP_W     = 16;
   localparam int CNT_W     = 16;
   localparam int OFF_W     = 25;
   localparam int GRAV_W    = 15;
   localparam int CSR_W     = 16;
   localparam int CSR_AW    = 2;
   localparam int NUM_AXES  = 6;
   localparam int NUM_ACC   = 3;
   localparam int AX_W      = 3;

   // averages never exceed one full-scale sample, in fraction units
   localparam int MAG_W     = SMP_W + FRAC_BITS;
   localparam int PROD_W    = 2 * MAG_W;
   localparam int DVD_W     = PROD_W;
   localparam int DSR_W     = MAG_W;
   localparam int ROOT_W    = MAG_W;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int DIV_CNT_W = $clog2(DVD_W);
   localparam int SQT_CNT_W = $clog2(ROOT_W);

   localparam logic [MAG_W-1:0] AVG_MAX = MAG_W'(1) << (MAG_W - 1);

   localparam logic [CNT_W-1:0]  TARGET_RST   = CNT_W'(100);
   localparam logic [GRAV_W-1:0] GRAVITY_RST  = GRAV_W'(16393);
   localparam logic [GRAV_W-1:0] MIN_NORM_RST = GRAV_W'(3279);

   typedef enum logic [CSR_AW-1:0] {
      CSR_TARGET   = 2'd0,
      CSR_GRAVITY  = 2'd1,
      CSR_MIN_NORM = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RUN,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_SQ_MUL,
      ST_SQ_ACC,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_CHECK,
      ST_EXP_MUL,
      ST_EXP_GO,
      ST_EXP_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DSR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic             start;
      logic [RAD_W-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_rsp_type;

endpackage

// ===== rtl/imu_sbc_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
module imu_sbc_div (
   input  logic                      clock,
   input  logic                      reset,
   input  imu_sbc_pkg::div_req_type  div_req,
   output imu_sbc_pkg::div_rsp_type  div_rsp
);
   import imu_sbc_pkg::*;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DSR_W-1:0]     rem_ff, rem_in;
   logic [DSR_W-1:0]     dsr_ff, dsr_in;
   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [DSR_W:0]       trial;
   logic [DSR_W:0]       diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DVD_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         run_in = 1'b1;
         cnt_in = DIV_CNT_W'(DVD_W - 1);
         rem_in = '0;
         dsr_in = div_req.divisor;
         quo_in = div_req.dividend;
      end else if (run_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[DSR_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DSR_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== rtl/imu_sbc_sqrt.sv =====
// digit-by-digit integer square root, one root bit per cycle
module imu_sbc_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  imu_sbc_pkg::sqrt_req_type  sqrt_req,
   output imu_sbc_pkg::sqrt_rsp_type  sqrt_rsp
);
   import imu_sbc_pkg::*;

   localparam int REM_W = ROOT_W + 2;
   localparam int SH_W  = ROOT_W + 4;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [SQT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RAD_W-1:0]     rad_ff, rad_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [ROOT_W-1:0]    root_ff, root_in;
   logic [SH_W-1:0]      rem_sh;
   logic [SH_W-1:0]      trial;
   logic [SH_W-1:0]      diff;

   always_comb begin
      rem_sh  = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      diff    = rem_sh - trial;
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (sqrt_req.start) begin
         run_in  = 1'b1;
         cnt_in  = SQT_CNT_W'(ROOT_W - 1);
         rad_in  = sqrt_req.radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (run_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = diff[REM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[REM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - SQT_CNT_W'(1);
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign sqrt_rsp.done = done_ff;
   assign sqrt_rsp.root = root_ff;

endmodule

// ===== rtl/imu_still_bias_calibrator.sv =====
// top level of the imu still bias calibrator: accumulation, sequencer and result registers
//
// A start command (req_cmd high, req_sample_ok high, nonzero target) opens a run and
// clears the six axis sums; starts during a run are dropped. Busy stays low during a
// run, so samples may come every cycle. A failed sample ends the run and the invalid
// result appears on the rsp_ ports in the next cycle. When the sample count reaches
// the target, busy rises and the finish sequence runs on one shared restoring divider,
// a 24 x 24 multiplier and a bit-serial square root: six averages, three squares, the
// norm, then, if the norm passes its minimum check, three gravity-scaled expected
// values. rsp_strobe is high for exactly one cycle per result and there is no
// backpressure: capture it when seen. Configuration writes are registered and should
// be made between runs or between samples of a run.
module imu_still_bias_calibrator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_cmd,
   input  logic                                  req_sample_ok,
   input  logic signed [imu_sbc_pkg::SMP_W-1:0]  req_accel_x,
   input  logic signed [imu_sbc_pkg::SMP_W-1:0]  req_accel_y,
   input  logic signed [imu_sbc_pkg::SMP_W-1:0]  req_accel_z,
   input  logic signed [imu_sbc_pkg::SMP_W-1:0]  req_gyro_x,
   input  logic signed [imu_sbc_pkg::SMP_W-1:0]  req_gyro_y,
   input  logic signed [imu_sbc_pkg::SMP_W-1:0]  req_gyro_z,
   output logic                                  rsp_strobe,
   output logic signed [imu_sbc_pkg::OFF_W-1:0]  rsp_accel_off_x,
   output logic signed [imu_sbc_pkg::OFF_W-1:0]  rsp_accel_off_y,
   output logic signed [imu_sbc_pkg::OFF_W-1:0]  rsp_accel_off_z,
   output logic signed [imu_sbc_pkg::OFF_W-1:0]  rsp_gyro_off_x,
   output logic signed [imu_sbc_pkg::OFF_W-1:0]  rsp_gyro_off_y,
   output logic signed [imu_sbc_pkg::OFF_W-1:0]  rsp_gyro_off_z,
   output logic                                  rsp_result_valid,
   input  logic                                  csr_we,
   input  logic [imu_sbc_pkg::CSR_AW-1:0]        csr_addr,
   input  logic [imu_sbc_pkg::CSR_W-1:0]         csr_wdata
);
   import imu_sbc_pkg::*;

   // accel offset difference is formed wide, then saturated
   localparam int DIFF_W = DVD_W + 2;
   localparam logic signed [OFF_W-1:0] OFF_MAX = {1'b0, {(OFF_W-1){1'b1}}};
   localparam logic signed [OFF_W-1:0] OFF_MIN = {1'b1, {(OFF_W-1){1'b0}}};
   localparam logic [AX_W-1:0] AX_LAST  = AX_W'(NUM_AXES - 1);
   localparam logic [AX_W-1:0] ACC_LAST = AX_W'(NUM_ACC - 1);

   typedef struct packed {
      logic busy;
      logic div_go;
      logic sqrt_go;
      logic emit_bad;
      logic emit_good;
   } ctrl_type;

   // configuration
   logic [CNT_W-1:0]  target_ff;
   logic [GRAV_W-1:0] gravity_ff;
   logic [GRAV_W-1:0] min_norm_ff;

   // sequencer
   state_type        state_ff, state_in;
   ctrl_type         ctrl;
   logic [AX_W-1:0]  ax_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_inc;
   logic             accept;
   logic             open_run;
   logic             good_smp;
   logic             bad_smp;
   logic             norm_bad;

   // run data
   logic signed [SMP_W-1:0] smp [NUM_AXES];
   logic signed [SUM_W-1:0] sums_ff [NUM_AXES];
   logic [MAG_W-1:0]        mag_ff [NUM_AXES];
   logic                    neg_ff [NUM_AXES];
   logic [PROD_W-1:0]       prod_ff;
   logic [RAD_W-1:0]        sq_ff;
   logic [ROOT_W-1:0]       norm_ff;

   // shared units
   div_req_type  div_req;
   div_rsp_type  div_rsp;
   sqrt_req_type sqrt_req;
   sqrt_rsp_type sqrt_rsp;

   logic signed [SUM_W-1:0] sum_sel;
   logic [SUM_W-1:0]        sum_mag;
   logic [MAG_W-1:0]        avg_q;
   logic [MAG_W-1:0]        mag_sel;
   logic [MAG_W-1:0]        gq;
   logic [MAG_W-1:0]        mul_b;
   logic [PROD_W-1:0]       mul_prod;
   logic signed [OFF_W-1:0] avg_sel;
   logic signed [DIFF_W-1:0] e_s;
   logic signed [DIFF_W-1:0] exp_s;
   logic signed [DIFF_W-1:0] diff;
   logic signed [OFF_W-1:0] acc_off;

   // results
   logic                    strobe_ff;
   logic                    valid_ff;
   logic signed [OFF_W-1:0] off_ff [NUM_AXES];

   function automatic logic signed [OFF_W-1:0] signed_avg(input logic [MAG_W-1:0] mag,
                                                          input logic neg);
      logic [OFF_W-1:0] m;
      m = OFF_W'(mag);
      return neg ? $signed(OFF_W'(0) - m) : $signed(m);
   endfunction

   assign smp[0] = req_accel_x;
   assign smp[1] = req_accel_y;
   assign smp[2] = req_accel_z;
   assign smp[3] = req_gyro_x;
   assign smp[4] = req_gyro_y;
   assign smp[5] = req_gyro_z;

   assign accept    = start && !ctrl.busy;
   assign open_run  = accept && req_cmd && req_sample_ok && (target_ff != '0);
   assign good_smp  = accept && !req_cmd && req_sample_ok;
   assign bad_smp   = accept && !req_cmd && !req_sample_ok;
   assign count_inc = count_ff + CNT_W'(1);
   assign norm_bad  = (norm_ff == '0) || (norm_ff < ROOT_W'({min_norm_ff, FRAC_BITS'(0)}));

   // axis operand selection for the shared units
   assign sum_sel = sums_ff[ax_ff];
   assign sum_mag = sum_sel[SUM_W-1] ? (SUM_W'(0) - $unsigned(sum_sel)) : $unsigned(sum_sel);
   assign mag_sel = mag_ff[ax_ff];
   assign gq      = MAG_W'({gravity_ff, FRAC_BITS'(0)});
   assign mul_b   = (state_ff == ST_EXP_MUL) ? gq : mag_sel;
   assign mul_prod = mag_sel * mul_b;

   // average magnitude, clamped to one full-scale sample
   assign avg_q = (div_rsp.quotient > DVD_W'(AVG_MAX)) ? AVG_MAX
                                                      : div_rsp.quotient[MAG_W-1:0];

   // accel offset: average minus its gravity-scaled copy, saturated
   assign avg_sel = signed_avg(mag_sel, neg_ff[ax_ff]);
   assign e_s     = $signed({2'b00, div_rsp.quotient});
   assign exp_s   = neg_ff[ax_ff] ? -e_s : e_s;
   assign diff    = DIFF_W'(avg_sel) - exp_s;

   always_comb begin
      priority if (diff > DIFF_W'(OFF_MAX)) begin
         acc_off = OFF_MAX;
      end else if (diff < DIFF_W'(OFF_MIN)) begin
         acc_off = OFF_MIN;
      end else begin
         acc_off = diff[OFF_W-1:0];
      end
   end

   // divider is loaded with an average or an expected value
   always_comb begin
      div_req.start = ctrl.div_go;
      if (state_ff == ST_AVG_GO) begin
         div_req.dividend = DVD_W'({sum_mag, FRAC_BITS'(0)});
         div_req.divisor  = DSR_W'(count_ff);
      end else begin
         div_req.dividend = prod_ff;
         div_req.divisor  = norm_ff;
      end
   end

   assign sqrt_req.start    = ctrl.sqrt_go;
   assign sqrt_req.radicand = sq_ff;

   imu_sbc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   imu_sbc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .sqrt_req (sqrt_req),
      .sqrt_rsp (sqrt_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (open_run) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (bad_smp) begin
               state_in = ST_IDLE;
            end else if (good_smp) begin
               // count wrap closes the run with an invalid result
               if (count_inc == '0) begin
                  state_in = ST_IDLE;
               end else if (count_inc >= target_ff) begin
                  state_in = ST_AVG_GO;
               end
            end
         end
         ST_AVG_GO:   state_in = ST_AVG_WAIT;
         ST_AVG_WAIT: begin
            if (div_rsp.done) begin
               state_in = (ax_ff == AX_LAST) ? ST_SQ_MUL : ST_AVG_GO;
            end
         end
         ST_SQ_MUL:   state_in = ST_SQ_ACC;
         ST_SQ_ACC:   state_in = (ax_ff == ACC_LAST) ? ST_SQRT_GO : ST_SQ_MUL;
         ST_SQRT_GO:  state_in = ST_SQRT_WAIT;
         ST_SQRT_WAIT: begin
            if (sqrt_rsp.done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK:    state_in = norm_bad ? ST_IDLE : ST_EXP_MUL;
         ST_EXP_MUL:  state_in = ST_EXP_GO;
         ST_EXP_GO:   state_in = ST_EXP_WAIT;
         ST_EXP_WAIT: begin
            if (div_rsp.done) begin
               state_in = (ax_ff == ACC_LAST) ? ST_EMIT : ST_EXP_MUL;
            end
         end
         ST_EMIT:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE: ;
         ST_RUN: begin
            ctrl.emit_bad = bad_smp || (good_smp && (count_inc == '0));
         end
         ST_AVG_GO: begin
            ctrl.busy   = 1'b1;
            ctrl.div_go = 1'b1;
         end
         ST_EXP_GO: begin
            ctrl.busy   = 1'b1;
            ctrl.div_go = 1'b1;
         end
         ST_SQRT_GO: begin
            ctrl.busy    = 1'b1;
            ctrl.sqrt_go = 1'b1;
         end
         ST_CHECK: begin
            ctrl.busy     = 1'b1;
            ctrl.emit_bad = norm_bad;
         end
         ST_EMIT: begin
            ctrl.busy      = 1'b1;
            ctrl.emit_good = 1'b1;
         end
         default: begin
            ctrl.busy = 1'b1;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         ax_ff       <= '0;
         count_ff    <= '0;
         strobe_ff   <= 1'b0;
         target_ff   <= TARGET_RST;
         gravity_ff  <= GRAVITY_RST;
         min_norm_ff <= MIN_NORM_RST;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= ctrl.emit_bad || ctrl.emit_good;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_TARGET:   target_ff   <= csr_wdata;
               CSR_GRAVITY:  gravity_ff  <= csr_wdata[GRAV_W-1:0];
               CSR_MIN_NORM: min_norm_ff <= csr_wdata[GRAV_W-1:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (open_run) begin
                  count_ff <= '0;
               end
            end
            ST_RUN: begin
               ax_ff <= '0;
               if (good_smp) begin
                  count_ff <= count_inc;
               end
            end
            ST_AVG_WAIT: begin
               if (div_rsp.done) begin
                  ax_ff <= (ax_ff == AX_LAST) ? '0 : ax_ff + AX_W'(1);
               end
            end
            ST_SQ_ACC: begin
               ax_ff <= (ax_ff == ACC_LAST) ? '0 : ax_ff + AX_W'(1);
            end
            ST_EXP_WAIT: begin
               if (div_rsp.done) begin
                  ax_ff <= ax_ff + AX_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (open_run) begin
               for (int i = 0; i < NUM_AXES; i++) begin
                  sums_ff[i] <= '0;
               end
            end
         end
         ST_RUN: begin
            if (good_smp) begin
               for (int i = 0; i < NUM_AXES; i++) begin
                  sums_ff[i] <= sums_ff[i] + SUM_W'(smp[i]);
               end
            end
         end
         ST_AVG_WAIT: begin
            if (div_rsp.done) begin
               mag_ff[ax_ff] <= avg_q;
               neg_ff[ax_ff] <= sum_sel[SUM_W-1];
               sq_ff         <= '0;
            end
         end
         ST_SQ_MUL:  prod_ff <= mul_prod;
         ST_SQ_ACC:  sq_ff   <= sq_ff + prod_ff;
         ST_SQRT_WAIT: begin
            if (sqrt_rsp.done) begin
               norm_ff <= sqrt_rsp.root;
            end
         end
         ST_EXP_MUL: prod_ff <= mul_prod;
         ST_EXP_WAIT: begin
            if (div_rsp.done) begin
               off_ff[ax_ff] <= acc_off;
            end
         end
         ST_EMIT: begin
            for (int i = NUM_ACC; i < NUM_AXES; i++) begin
               off_ff[i] <= signed_avg(mag_ff[i], neg_ff[i]);
            end
         end
         default: ;
      endcase
      // an aborted or rejected run reports all offsets zero
      if (ctrl.emit_bad) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            off_ff[i] <= '0;
         end
         valid_ff <= 1'b0;
      end else if (ctrl.emit_good) begin
         valid_ff <= 1'b1;
      end
   end

   assign busy             = ctrl.busy;
   assign rsp_strobe       = strobe_ff;
   assign rsp_result_valid = valid_ff;
   assign rsp_accel_off_x  = off_ff[0];
   assign rsp_accel_off_y  = off_ff[1];
   assign rsp_accel_off_z  = off_ff[2];
   assign rsp_gyro_off_x   = off_ff[3];
   assign rsp_gyro_off_y   = off_ff[4];
   assign rsp_gyro_off_z   = off_ff[5];

endmodule
